>>> src/sorted_deadline_timer_queue_defines.svh
// assertion macros for the sorted deadline timer queue
// no dependencies; define NO_ASSERTIONS to drop all checks
`ifndef SORTED_DEADLINE_TIMER_QUEUE_DEFINES_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SDTQ_ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SDTQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SDTQ_ASSERT_IMPL(lbl, clk, rst_n, prop, msg)
`define SDTQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> src/sdtq_pkg.sv
// shared types and constants for the sorted deadline timer queue
// no dependencies
package sdtq_pkg;
    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;
    localparam logic       EV_FIRED   = 1'b0;
    localparam logic       EV_REMOVE  = 1'b1;
    localparam logic [63:0] FAR_US    = 64'd31104000000000000;
    localparam logic [55:0] REM_MAX   = {56{1'b1}};
    localparam int unsigned MAX_RES   = 16;

    // command broadcast to every cell
    localparam logic [1:0] CMD_NONE   = 2'd0;
    localparam logic [1:0] CMD_PLACE  = 2'd1;
    localparam logic [1:0] CMD_UNLINK = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [5:0]  slot;
        logic [63:0] deadline;
    } t_cell_cmd;

    typedef struct packed {
        logic        valid;
        logic [5:0]  slot;
        logic [63:0] deadline;
    } t_cell_data;
endpackage

>>> src/sdtq_cell.sv
// one queue cell: holds a slot id and a deadline, shifts with its neighbors
// depends on sdtq_pkg
module sdtq_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sdtq_pkg::t_cell_cmd   i_cmd,
    input  sdtq_pkg::t_cell_data  i_left,
    input  logic                  i_left_goes_right,
    input  logic                  i_left_stays,
    input  sdtq_pkg::t_cell_data  i_right,
    output sdtq_pkg::t_cell_data  o_data,
    output logic                  o_later,
    output logic                  o_removing
);
    import sdtq_pkg::*;
    logic        r_valid;
    logic [5:0]  r_slot;
    logic [63:0] r_deadline;
    logic        w_ins_here;

    assign o_data     = '{valid: r_valid, slot: r_slot, deadline: r_deadline};
    // an empty cell counts as later, so a new item lands at the end
    assign o_later    = !r_valid || (r_deadline > i_cmd.deadline);
    assign o_removing = r_valid && (r_slot == i_cmd.slot);
    // the first later cell takes the new item; its left neighbor keeps its entry
    assign w_ins_here = o_later && i_left_stays;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            case (i_cmd.cmd)
                CMD_PLACE: begin
                    if (i_left_goes_right) begin
                        r_valid    <= i_left.valid;
                        r_slot     <= i_left.slot;
                        r_deadline <= i_left.deadline;
                    end else if (w_ins_here) begin
                        r_valid    <= 1'b1;
                        r_slot     <= i_cmd.slot;
                        r_deadline <= i_cmd.deadline;
                    end
                end
                CMD_UNLINK: begin
                    if (i_left_goes_right) begin
                        r_valid    <= i_right.valid;
                        r_slot     <= i_right.slot;
                        r_deadline <= i_right.deadline;
                    end
                end
                default: begin
                end
            endcase
        end
    end
endmodule

>>> src/sdtq_div.sv
// restoring divider for remaining time, one quotient bit per cycle
// depends on nothing
module sdtq_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [9:0]  i_den,
    output logic        o_done,
    output logic [63:0] o_quo,
    output logic        o_rem_nz
);
    logic [63:0] r_quo;
    logic [10:0] r_rem;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [9:0]  r_den;
    logic [10:0] w_try;
    logic        w_fit;

    assign w_try    = {r_rem[9:0], r_quo[63]};
    assign w_fit    = w_try >= {1'b0, r_den};
    assign o_quo    = r_quo;
    assign o_rem_nz = r_rem != '0;
    assign o_done   = r_busy && (r_cnt == 7'd64);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_quo  <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (r_cnt == 7'd64) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 7'd1;
                r_rem <= w_fit ? (w_try - {1'b0, r_den}) : w_try;
                r_quo <= {r_quo[62:0], w_fit};
            end
        end
    end
endmodule

>>> src/sorted_deadline_timer_queue.sv
// top level of the sorted deadline timer queue: control sequencer and cell chain
// depends on sdtq_pkg, sdtq_cell, sdtq_div and sorted_deadline_timer_queue_defines.svh
//
//  channel  | direction | handshake       | payload
//  ---------+-----------+-----------------+---------------------------------------
//  request  | in        | valid / stall   | req_type, slot, delay_us, repeating
//  event    | out       | valid / stall   | event_kind, event_slot, remaining_us, last
//  config   | in        | valid / ready   | ticks_per_us
//
// a tick runs accept and check; an insert runs accept, multiply, unlink, place and check
// each fired slot adds fire, multiply, re-arm and emit, and a place when it re-arms,
// plus any stall on the event side; a remove runs accept, lookup and emit when the slot
// is not queued, and a queued slot adds the 64-step remaining-time divide and a check
// reset is synchronous and clears now, the cell valid bits and the fired flags
// a stall on the event side holds the sequencer in whichever emit state it has reached
`include "sorted_deadline_timer_queue_defines.svh"
module sorted_deadline_timer_queue #(
    parameter int NUM_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [3:0]  i_slot,
    input  logic [31:0] i_delay_us,
    input  logic        i_repeating,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_event_kind,
    output logic [3:0]  o_event_slot,
    output logic [55:0] o_remaining_us,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [9:0]  i_cfg_data
);
    import sdtq_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_INS_MUL= 4'd1;
    localparam logic [3:0] ST_INS_UNL= 4'd2;
    localparam logic [3:0] ST_PLACE  = 4'd3;
    localparam logic [3:0] ST_CHECK  = 4'd4;
    localparam logic [3:0] ST_FIRE   = 4'd5;
    localparam logic [3:0] ST_REARM  = 4'd6;
    localparam logic [3:0] ST_EMIT   = 4'd7;
    localparam logic [3:0] ST_REM_DIV= 4'd8;
    localparam logic [3:0] ST_REM_WAIT=4'd9;
    localparam logic [3:0] ST_REM_UNL= 4'd10;
    localparam logic [3:0] ST_REM_EMIT=4'd11;
    localparam logic [3:0] ST_FIRE_MUL=4'd12;

    logic [3:0]  r_state;
    logic [63:0] r_now;
    logic [9:0]  r_rate;
    logic [NUM_SLOTS-1:0] r_fired;
    logic [31:0] r_period [NUM_SLOTS];

    // latched request
    logic [5:0]  r_slot;
    logic [31:0] r_delay;
    logic [63:0] r_prod;
    logic [63:0] r_dl;
    logic [4:0]  r_nres;
    // pending result
    logic        r_ev_kind;
    logic [3:0]  r_ev_slot;
    logic [55:0] r_ev_rem;
    logic        r_ev_pend;
    logic        r_found;
    logic [63:0] r_diff;

    t_cell_cmd   w_cmd;
    t_cell_data  w_data  [NUM_SLOTS];
    t_cell_data  w_left  [NUM_SLOTS];
    t_cell_data  w_right [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] w_later, w_rmv, w_shift, w_stay;
    logic [9:0]  w_rate;
    logic [63:0] w_sum, w_dl;
    logic        w_head_due;
    logic        w_div_start, w_div_done, w_div_nz;
    logic [63:0] w_div_q;
    logic [63:0] w_rem64;
    logic        w_in_acc, w_out_acc;
    logic [63:0] w_rem_dl;
    logic [5:0]  w_in_slot;

    assign w_in_slot = {2'b00, i_slot};
    assign w_rate  = (r_rate == '0) ? 10'd1 : r_rate;
    assign o_stall = (r_state != ST_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = o_valid && !i_stall;
    // deadline from the registered product; wrap falls back to the far deadline
    assign w_sum = r_now + r_prod;
    assign w_dl  = (w_sum < r_now) ? 64'(FAR_US * 64'(w_rate)) : w_sum;
    assign w_head_due = w_data[0].valid && (w_data[0].deadline == r_now);

    // command broadcast to the chain
    always_comb begin
        w_cmd = '{cmd: CMD_NONE, slot: r_slot, deadline: r_dl};
        case (r_state)
            ST_INS_UNL, ST_REM_UNL: w_cmd.cmd = CMD_UNLINK;
            ST_FIRE: begin
                w_cmd.cmd  = CMD_UNLINK;
                w_cmd.slot = w_data[0].slot;
            end
            ST_PLACE: w_cmd.cmd = CMD_PLACE;
            default: w_cmd.cmd = CMD_NONE;
        endcase
    end

    // neighbor wiring: place shifts right from the insertion point,
    // unlink shifts left from the removed cell
    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_chain
        assign w_left[g]  = (g == 0) ? t_cell_data'('0) : w_data[(g == 0) ? 0 : g-1];
        assign w_right[g] = (g == NUM_SLOTS-1) ? t_cell_data'('0)
                                               : w_data[(g == NUM_SLOTS-1) ? g : g+1];
        if (g == 0) begin : g_first
            assign w_shift[g] = (w_cmd.cmd == CMD_UNLINK) ? w_rmv[0] : 1'b0;
            assign w_stay[g]  = 1'b1;
        end else begin : g_rest
            assign w_shift[g] = (w_cmd.cmd == CMD_UNLINK)
                ? (w_rmv[g] || w_shift[g-1])
                : (w_later[g-1] && w_data[g-1].valid);
            // left neighbor holds an entry no later than the new one, which stays in place
            assign w_stay[g]  = w_data[g-1].valid && !w_later[g-1];
        end
        sdtq_cell u_cell (
            .i_clk            (i_clk),
            .i_rst_n          (i_rst_n),
            .i_cmd            (w_cmd),
            .i_left           (w_left[g]),
            .i_left_goes_right(w_shift[g]),
            .i_left_stays     (w_stay[g]),
            .i_right          (w_right[g]),
            .o_data           (w_data[g]),
            .o_later          (w_later[g]),
            .o_removing       (w_rmv[g])
        );
    end

    // lookup of the removed slot's deadline, a mux over the cells
    always_comb begin
        w_rem_dl = '0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (w_rmv[k]) begin
                w_rem_dl = w_data[k].deadline;
            end
        end
    end

    assign w_div_start = (r_state == ST_REM_DIV);
    sdtq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_diff),
        .i_den   (w_rate),
        .o_done  (w_div_done),
        .o_quo   (w_div_q),
        .o_rem_nz(w_div_nz)
    );
    assign w_rem64 = w_div_q + {63'd0, w_div_nz};

    assign o_valid        = r_ev_pend;
    assign o_event_kind   = r_ev_kind;
    assign o_event_slot   = r_ev_slot;
    assign o_remaining_us = r_ev_rem;
    // a result is last when nothing can follow it
    assign o_last = (r_ev_kind == EV_REMOVE) ? !r_found || !w_head_due || (r_nres == 5'd16)
                                             : !w_head_due || (r_nres == 5'd16);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && w_in_acc && i_req_type == REQ_INSERT
                && 32'(i_slot) < 32'(NUM_SLOTS)) begin
            r_period[w_in_slot[$clog2(NUM_SLOTS)-1:0]] <= i_repeating ? i_delay_us : 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_now     <= '0;
            r_rate    <= 10'd1;
            r_fired   <= '0;
            r_ev_pend <= 1'b0;
            r_nres    <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_cfg_valid) begin
                        r_rate <= i_cfg_data;
                    end else if (w_in_acc) begin
                        r_slot  <= w_in_slot;
                        r_delay <= i_delay_us;
                        r_nres  <= '0;
                        r_found <= 1'b0;
                        case (i_req_type)
                            REQ_TICK: begin
                                r_now   <= r_now + 64'd1;
                                r_state <= ST_CHECK;
                            end
                            REQ_INSERT: begin
                                if (32'(i_slot) < 32'(NUM_SLOTS)) begin
                                    r_fired[w_in_slot[$clog2(NUM_SLOTS)-1:0]] <= 1'b0;
                                    r_state <= ST_INS_MUL;
                                end
                            end
                            REQ_REMOVE: r_state <= ST_REM_UNL;
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_INS_MUL: begin
                    r_prod  <= 64'(r_delay) * 64'(w_rate);
                    r_state <= ST_INS_UNL;
                end
                ST_INS_UNL: begin
                    r_dl    <= w_dl;
                    r_state <= ST_PLACE;
                end
                ST_PLACE: begin
                    r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (w_head_due && r_nres != 5'd16) begin
                        r_slot  <= w_data[0].slot;
                        r_state <= ST_FIRE;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_FIRE: begin
                    r_ev_kind <= EV_FIRED;
                    r_ev_slot <= r_slot[3:0];
                    r_ev_rem  <= '0;
                    r_delay   <= r_period[r_slot[$clog2(NUM_SLOTS)-1:0]];
                    r_state   <= ST_FIRE_MUL;
                end
                ST_FIRE_MUL: begin
                    r_prod  <= 64'(r_delay) * 64'(w_rate);
                    r_state <= ST_REARM;
                end
                ST_REARM: begin
                    if (r_delay != '0 && w_dl != r_now) begin
                        r_dl <= w_dl;
                        r_state <= ST_EMIT;
                        r_found <= 1'b1;
                    end else begin
                        r_fired[r_slot[$clog2(NUM_SLOTS)-1:0]] <= 1'b1;
                        r_found <= 1'b0;
                        r_state <= ST_EMIT;
                    end
                    r_nres    <= r_nres + 5'd1;
                end
                ST_EMIT: begin
                    // show the fired item, then requeue a re-armed slot
                    if (!r_ev_pend) begin
                        r_ev_pend <= 1'b1;
                    end else if (w_out_acc) begin
                        r_ev_pend <= 1'b0;
                        r_found   <= 1'b0;
                        r_state   <= r_found ? ST_PLACE : ST_CHECK;
                    end
                end
                ST_REM_UNL: begin
                    r_found <= 1'b0;
                    if (32'(r_slot) < 32'(NUM_SLOTS) && !r_fired[r_slot[$clog2(NUM_SLOTS)-1:0]]
                            && (|w_rmv)) begin
                        r_found <= 1'b1;
                        r_diff  <= w_rem_dl - r_now;
                        r_state <= ST_REM_DIV;
                    end else begin
                        r_ev_rem <= '0;
                        r_state  <= ST_REM_EMIT;
                    end
                    r_ev_kind <= EV_REMOVE;
                    r_ev_slot <= r_slot[3:0];
                end
                ST_REM_DIV: r_state <= ST_REM_WAIT;
                ST_REM_WAIT: begin
                    if (w_div_done) begin
                        r_ev_rem <= (w_rem64 > 64'(REM_MAX)) ? REM_MAX : w_rem64[55:0];
                        r_state  <= ST_REM_EMIT;
                    end
                end
                ST_REM_EMIT: begin
                    if (!r_ev_pend) begin
                        r_ev_pend <= 1'b1;
                        r_nres    <= 5'd1;
                    end else if (w_out_acc) begin
                        r_ev_pend <= 1'b0;
                        r_state   <= r_found ? ST_CHECK : ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // a remove unlinks its cell in the lookup cycle, before the divide starts

    `SDTQ_ASSERT_IMPL(a_out_only_busy, i_clk, i_rst_n, o_valid |-> (r_state != ST_IDLE), "result shown while idle")
    `SDTQ_ASSERT_NEXT(a_cfg_idle, i_clk, i_rst_n, i_cfg_valid && o_cfg_ready, r_rate == $past(i_cfg_data), "config write lost")
    `SDTQ_ASSERT_IMPL(a_head_sorted, i_clk, i_rst_n, (w_data[0].valid || !w_data[1].valid), "queue has a hole at its head")
    `SDTQ_ASSERT_NEXT(a_tick_adv, i_clk, i_rst_n, w_in_acc && i_req_type == REQ_TICK, r_now == $past(r_now) + 64'd1, "tick did not advance")
endmodule

>>> tb/sorted_deadline_timer_queue_tb.sv
// self-checking testbench for the sorted deadline timer queue
// depends on sdtq_pkg and the sorted_deadline_timer_queue top level
// a directed table, then random ticks, inserts and removes under several rates
module sorted_deadline_timer_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sdtq_pkg::*;

    localparam int          SLOTS    = 16;
    localparam logic [1:0]  REQ_IDLE = 2'd3;   // unused request code, gives no result
    localparam int          SETTLE   = 300;    // cycles covering divide plus a full burst of fires

    // one expected event
    typedef struct {
        logic        kind;
        logic [3:0]  slot;
        logic [55:0] rem;
        logic        last;
    } t_event;

    // one row of the directed table; typed rows carry their single expected event
    typedef struct {
        logic [1:0]  req;
        logic [3:0]  slot;
        logic [31:0] delay;
        logic        rep;
        bit          typed;
        logic        ekind;
        logic [3:0]  eslot;
        logic [55:0] erem;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_req_type;
    logic [3:0]  i_slot;
    logic [31:0] i_delay_us;
    logic        i_repeating;
    logic        o_valid;
    logic        i_stall;
    logic        o_event_kind;
    logic [3:0]  o_event_slot;
    logic [55:0] o_remaining_us;
    logic        o_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [9:0]  i_cfg_data;

    sorted_deadline_timer_queue #(.NUM_SLOTS(SLOTS)) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_slot         (i_slot),
        .i_delay_us     (i_delay_us),
        .i_repeating    (i_repeating),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_event_kind   (o_event_kind),
        .o_event_slot   (o_event_slot),
        .o_remaining_us (o_remaining_us),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    // 4 ns clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // timer queue shadow: tick counter, sorted cells, per-slot state
    // ---------------------------------------------------------------
    logic [63:0] now_q;
    logic [9:0]  rate_q;
    logic [3:0]  q_slot  [SLOTS];
    logic [63:0] q_dl    [SLOTS];
    int          q_count;
    logic [31:0] period_q [SLOTS];
    bit          fired_q  [SLOTS];

    t_event      pending_events[$];   // events still owed by the block
    t_event      step_events[$];      // events of the item being predicted

    int  mismatches;
    bit  out_taken;   // event accepted at the coming edge
    bit  calm;        // no idling on either side while set

    function automatic logic [63:0] eff_rate();
        return (rate_q == 10'd0) ? 64'd1 : {54'd0, rate_q};
    endfunction

    function automatic logic [63:0] deadline_of(logic [31:0] us);
        logic [63:0] d;
        d = now_q + {32'd0, us} * eff_rate();
        if (d < now_q)
            d = eff_rate() * FAR_US;
        return d;
    endfunction

    function automatic int find_cell(logic [3:0] s);
        for (int i = 0; i < q_count; i++)
            if (q_slot[i] == s)
                return i;
        return -1;
    endfunction

    function automatic void drop_cell(int idx);
        if (idx < 0 || idx >= q_count)
            return;
        for (int i = idx; i + 1 < q_count; i++) begin
            q_slot[i] = q_slot[i + 1];
            q_dl[i]   = q_dl[i + 1];
        end
        q_count--;
    endfunction

    // equal deadlines keep insertion order: place after every cell not later
    function automatic void place_cell(logic [3:0] s, logic [63:0] dl);
        int pos;
        if (q_count >= SLOTS)
            return;
        pos = q_count;
        for (int i = 0; i < q_count; i++)
            if (q_dl[i] > dl) begin
                pos = i;
                break;
            end
        for (int i = q_count; i > pos; i--) begin
            q_slot[i] = q_slot[i - 1];
            q_dl[i]   = q_dl[i - 1];
        end
        q_slot[pos] = s;
        q_dl[pos]   = dl;
        q_count++;
    endfunction

    function automatic void add_event(logic kind, logic [3:0] s, logic [55:0] rem);
        t_event e;
        if (step_events.size() >= MAX_RES)
            return;
        e.kind = kind;
        e.slot = s;
        e.rem  = rem;
        e.last = 1'b0;
        step_events.push_back(e);
    endfunction

    // pop every head that is due now; repeating slots re-arm unless they land on now
    function automatic void fire_heads();
        int guard;
        logic [3:0]  s;
        logic [63:0] d;
        guard = 0;
        while (guard < SLOTS && q_count > 0 && q_dl[0] == now_q) begin
            s = q_slot[0];
            guard++;
            drop_cell(0);
            if (period_q[s] != 32'd0) begin
                d = deadline_of(period_q[s]);
                if (d != now_q)
                    place_cell(s, d);
                else
                    fired_q[s] = 1'b1;
            end else begin
                fired_q[s] = 1'b1;
            end
            add_event(EV_FIRED, s, 56'd0);
        end
    endfunction

    // advance the shadow by one request and collect the events it causes
    function automatic void timer_step(logic [1:0] req, logic [3:0] s, logic [31:0] delay,
                                       logic rep);
        int idx;
        logic [63:0] diff;
        logic [63:0] rem;
        step_events.delete();
        case (req)
            REQ_TICK: begin
                now_q = now_q + 64'd1;
                fire_heads();
            end
            REQ_INSERT: begin
                drop_cell(find_cell(s));
                period_q[s] = rep ? delay : 32'd0;
                fired_q[s]  = 1'b0;
                place_cell(s, deadline_of(delay));
                fire_heads();
            end
            REQ_REMOVE: begin
                rem = 64'd0;
                idx = fired_q[s] ? -1 : find_cell(s);
                if (idx >= 0) begin
                    diff = q_dl[idx] - now_q;
                    rem  = diff / eff_rate() + ((diff % eff_rate()) != 0 ? 64'd1 : 64'd0);
                    if (rem > {8'd0, REM_MAX})
                        rem = {8'd0, REM_MAX};
                    drop_cell(idx);
                end
                add_event(EV_REMOVE, s, rem[55:0]);
                if (idx >= 0)
                    fire_heads();
            end
            default: begin
            end
        endcase
        if (step_events.size() > 0)
            step_events[step_events.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // event side: random stall, checking at the falling edge
    // ---------------------------------------------------------------
    int stall_left;
    initial begin
        stall_left = 0;
        i_stall    = 1'b1;
        forever begin
            @(posedge i_clk);
            if (out_taken)
                stall_left = calm ? 0 : $urandom_range(0, 10);
            i_stall <= (stall_left != 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    initial begin
        t_event e;
        mismatches = 0;
        out_taken  = 1'b0;
        forever begin
            @(negedge i_clk);
            out_taken = i_rst_n && o_valid && !i_stall;
            if (out_taken) begin
                if (pending_events.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected event: kind %0d slot %0d rem %0d last %0d",
                                 o_event_kind, o_event_slot, o_remaining_us, o_last);
                end else begin
                    e = pending_events.pop_front();
                    if (o_event_kind !== e.kind || o_event_slot !== e.slot ||
                        o_remaining_us !== e.rem || o_last !== e.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("event mismatch: exp kind %0d slot %0d rem %0d last %0d, got kind %0d slot %0d rem %0d last %0d",
                                     e.kind, e.slot, e.rem, e.last, o_event_kind,
                                     o_event_slot, o_remaining_us, o_last);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // request and config drivers
    // ---------------------------------------------------------------
    task automatic send_request(logic [1:0] req, logic [3:0] s, logic [31:0] delay, logic rep,
                                bit typed, t_event typed_ev);
        int gap;
        bit taken;
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_req_type  <= req;
        i_slot      <= s;
        i_delay_us  <= delay;
        i_repeating <= rep;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end
        // the item went in at this edge; valid is left to the next call or the end
        timer_step(req, s, delay, rep);
        if (typed)
            pending_events.push_back(typed_ev);
        else
            foreach (step_events[i])
                pending_events.push_back(step_events[i]);
    endtask

    // drain outstanding events, let the block settle, then write the rate
    task automatic write_rate(logic [9:0] value);
        bit taken;
        i_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        rate_q = value;
    endtask

    task automatic random_request();
        int pick;
        logic [1:0]  req;
        logic [31:0] delay;
        t_event none;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            req = REQ_TICK;
        else if (pick < 75)
            req = REQ_INSERT;
        else if (pick < 95)
            req = REQ_REMOVE;
        else
            req = REQ_IDLE;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            delay = $urandom_range(0, 8);
        else if (pick < 9)
            delay = $urandom_range(0, 200);
        else
            delay = $urandom;
        send_request(req, 4'($urandom_range(0, 15)), delay, 1'($urandom_range(0, 1)),
                     1'b0, none);
    endtask

    // directed rows, starting from reset state at rate 1
    t_row directed[] = '{
        '{REQ_TICK,   4'd0,  32'd0,          1'b0, 0, EV_FIRED,  4'd0,  56'd0},
        '{REQ_REMOVE, 4'd3,  32'd0,          1'b0, 1, EV_REMOVE, 4'd3,  56'd0},
        '{REQ_INSERT, 4'd0,  32'd0,          1'b0, 1, EV_FIRED,  4'd0,  56'd0},
        '{REQ_REMOVE, 4'd0,  32'd0,          1'b0, 1, EV_REMOVE, 4'd0,  56'd0},
        '{REQ_INSERT, 4'd15, 32'hFFFF_FFFF,  1'b1, 0, EV_FIRED,  4'd0,  56'd0},
        '{REQ_REMOVE, 4'd15, 32'd0,          1'b0, 1, EV_REMOVE, 4'd15, 56'hFFFF_FFFF},
        '{REQ_INSERT, 4'd1,  32'd2,          1'b1, 0, EV_FIRED,  4'd0,  56'd0},
        '{REQ_INSERT, 4'd2,  32'd2,          1'b0, 0, EV_FIRED,  4'd0,  56'd0},
        '{REQ_INSERT, 4'd3,  32'd1,          1'b0, 0, EV_FIRED,  4'd0,  56'd0},
        '{REQ_TICK,   4'd0,  32'd0,          1'b0, 0, EV_FIRED,  4'd0,  56'd0},
        '{REQ_TICK,   4'd0,  32'd0,          1'b0, 0, EV_FIRED,  4'd0,  56'd0},
        '{REQ_TICK,   4'd0,  32'd0,          1'b0, 0, EV_FIRED,  4'd0,  56'd0},
        '{REQ_TICK,   4'd0,  32'd0,          1'b0, 0, EV_FIRED,  4'd0,  56'd0},
        '{REQ_INSERT, 4'd4,  32'd0,          1'b1, 1, EV_FIRED,  4'd4,  56'd0},
        '{REQ_REMOVE, 4'd4,  32'd0,          1'b0, 1, EV_REMOVE, 4'd4,  56'd0},
        '{REQ_INSERT, 4'd5,  32'd5,          1'b0, 0, EV_FIRED,  4'd0,  56'd0},
        '{REQ_INSERT, 4'd5,  32'd1,          1'b1, 0, EV_FIRED,  4'd0,  56'd0},
        '{REQ_TICK,   4'd0,  32'd0,          1'b0, 0, EV_FIRED,  4'd0,  56'd0},
        '{REQ_INSERT, 4'd6,  32'h5555_5555,  1'b0, 0, EV_FIRED,  4'd0,  56'd0},
        '{REQ_REMOVE, 4'd6,  32'd0,          1'b0, 0, EV_FIRED,  4'd0,  56'd0},
        '{REQ_IDLE,   4'd7,  32'hAAAA_AAAA,  1'b1, 0, EV_FIRED,  4'd0,  56'd0},
        '{REQ_REMOVE, 4'd1,  32'd0,          1'b0, 0, EV_FIRED,  4'd0,  56'd0},
        '{REQ_REMOVE, 4'd5,  32'd0,          1'b0, 0, EV_FIRED,  4'd0,  56'd0}
    };

    // main sequence
    initial begin
        logic [9:0] rates[5];
        t_event ev;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_req_type  = REQ_TICK;
        i_slot      = 4'd0;
        i_delay_us  = 32'd0;
        i_repeating = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = 10'd1;
        calm        = 1'b0;
        now_q       = 64'd0;
        rate_q      = 10'd1;
        q_count     = 0;
        for (int i = 0; i < SLOTS; i++) begin
            period_q[i] = 32'd0;
            fired_q[i]  = 1'b0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at rate 1
        write_rate(10'd1);
        foreach (directed[i]) begin
            ev.kind = directed[i].ekind;
            ev.slot = directed[i].eslot;
            ev.rem  = directed[i].erem;
            ev.last = 1'b1;
            send_request(directed[i].req, directed[i].slot, directed[i].delay,
                         directed[i].rep, directed[i].typed, ev);
        end

        // random part across rates: top, zero (acts as one), full field, mid, one
        rates = '{10'd512, 10'd0, 10'd1023, 10'($urandom_range(2, 511)), 10'd1};
        foreach (rates[p]) begin
            write_rate(rates[p]);
            for (int n = 0; n < 36; n++) begin
                // a stretch with no idling every so often
                calm = (n % 12) < 3;
                random_request();
            end
            calm = 1'b0;
        end

        i_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && pending_events.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // run limit
    initial begin
        #2ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule

>>> sim.f
+incdir+src
src/sdtq_pkg.sv
src/sdtq_cell.sv
src/sdtq_div.sv
src/sorted_deadline_timer_queue.sv
tb/sorted_deadline_timer_queue_tb.sv
